[rtl/core/mcbll_pkg.sv]
// Shared types and constants of the motion command buffer.
// Used by every module in rtl/core; depends on nothing else.
package mcbll_pkg;

   // Request types
   localparam logic [1:0] REQ_FRAME  = 2'd0;
   localparam logic [1:0] REQ_SWITCH = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;

   // Result kinds
   localparam logic [1:0] RES_NONE   = 2'd0;
   localparam logic [1:0] RES_ROTATE = 2'd1;
   localparam logic [1:0] RES_SWITCH = 2'd2;
   localparam logic [1:0] RES_ATTEND = 2'd3;

   // Switch event codes
   localparam logic [2:0] EV_FWD_REACHED  = 3'd0;
   localparam logic [2:0] EV_REV_REACHED  = 3'd1;
   localparam logic [2:0] EV_FWD_RELEASED = 3'd2;
   localparam logic [2:0] EV_REV_RELEASED = 3'd3;
   localparam logic [2:0] EV_NONE         = 3'd4;

   // Lock states
   localparam logic [1:0] LOCK_NONE = 2'd0;
   localparam logic [1:0] LOCK_FWD  = 2'd1;
   localparam logic [1:0] LOCK_REV  = 2'd2;

   // Operation code of a rotation
   localparam logic [7:0] OP_ROTATE = 8'd0;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_NODE_ID    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_ID    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_START_ID   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PACKAGE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CLEAR      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ATTENDANCE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FORWARD    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_REVERSE    = 3'd7;
   localparam int unsigned CSR_DATA_W = 11;

   // One stored operation
   typedef struct packed {
      logic [7:0]  code;
      logic [7:0]  dir;
      logic [31:0] angle;
      logic [7:0]  rpm;
   } op_type;

   // Configuration registers
   typedef struct packed {
      logic [10:0] node_id;
      logic [10:0] stop_id;
      logic [10:0] start_id;
      logic [7:0]  package_kind;
      logic [7:0]  clear_kind;
      logic [7:0]  attendance_kind;
      logic [7:0]  forward_code;
      logic [7:0]  reverse_code;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      node_id:         11'd2,
      stop_id:         11'd0,
      start_id:        11'd1,
      package_kind:    8'd0,
      clear_kind:      8'd1,
      attendance_kind: 8'd2,
      forward_code:    8'd0,
      reverse_code:    8'd1
   };

   // One input request
   typedef struct packed {
      logic [1:0]  req_type;
      logic [10:0] frame_id;
      logic [3:0]  frame_len;
      logic [7:0]  data_kind;
      logic [7:0]  op_code;
      logic [7:0]  direction_code;
      logic [31:0] angle_bits;
      logic [7:0]  speed_rpm;
      logic        fwd_closed;
      logic        rev_closed;
   } item_type;

   // One result, without the stored count
   typedef struct packed {
      logic [1:0]  result_kind;
      logic        disable_driver;
      logic [7:0]  move_direction;
      logic [31:0] move_angle_bits;
      logic [7:0]  move_rpm;
      logic [2:0]  switch_event_code;
      logic        executing;
   } result_type;

endpackage

[rtl/core/mcb_op_store.sv]
// Operation store: one write port, one registered read port.
// Depends on mcbll_pkg for the operation type.
module mcb_op_store #(
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  mcbll_pkg::op_type    wr_data,
   input  logic [ADDR_W-1:0]    rd_addr,
   output mcbll_pkg::op_type    rd_data
);
   import mcbll_pkg::*;

   op_type mem [DEPTH];
   op_type rd_data_ff;

   // Write, and read with the write data passed through on an address match.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/mcb_ctrl.sv]
// Decision logic and state of the command buffer: mode, lock, count, index.
// Depends on mcbll_pkg; drives the operation store ports.
module mcb_ctrl #(
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = 4,
   parameter int unsigned CNT_W  = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  mcbll_pkg::item_type      item,
   input  mcbll_pkg::cfg_type       cfg,
   input  mcbll_pkg::op_type        rd_op,
   output logic [ADDR_W-1:0]        rd_addr,
   output logic                     wr_en,
   output logic [ADDR_W-1:0]        wr_addr,
   output mcbll_pkg::op_type        wr_op,
   output mcbll_pkg::result_type    rsp,
   output logic [CNT_W-1:0]         rsp_count
);
   import mcbll_pkg::*;

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

   logic             exec_ff, exec_in;
   logic [1:0]       lock_ff, lock_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] index_ff, index_in;

   // Per-request decision
   always_comb begin
      exec_in  = exec_ff;
      lock_in  = lock_ff;
      count_in = count_ff;
      index_in = index_ff;
      wr_en    = 1'b0;
      rsp      = '0;
      rsp.switch_event_code = EV_NONE;
      if (in_valid) begin
         unique case (item.req_type)
            REQ_FRAME: begin
               if (item.frame_id == cfg.stop_id) begin
                  exec_in = 1'b0;
                  rsp.disable_driver = 1'b1;
               end else if (item.frame_id == cfg.start_id) begin
                  exec_in = 1'b1;
               end else if (item.frame_id == cfg.node_id) begin
                  exec_in = 1'b0;
                  if (item.frame_len != 4'd0) begin
                     if (item.data_kind == cfg.package_kind) begin
                        // A full store drops the appended operation.
                        if (count_ff < DEPTH_C) begin
                           wr_en    = 1'b1;
                           count_in = count_ff + ONE_C;
                        end
                     end else if (item.data_kind == cfg.clear_kind) begin
                        count_in = '0;
                        index_in = '0;
                     end else if (item.data_kind == cfg.attendance_kind) begin
                        rsp.result_kind = RES_ATTEND;
                     end
                  end
               end
            end
            REQ_SWITCH: begin
               exec_in = 1'b0;
               rsp.result_kind    = RES_SWITCH;
               rsp.disable_driver = 1'b1;
               if (item.fwd_closed) begin
                  lock_in = LOCK_FWD;
                  rsp.switch_event_code = EV_FWD_REACHED;
               end
               if (item.rev_closed) begin
                  lock_in = LOCK_REV;
                  rsp.switch_event_code = EV_REV_REACHED;
               end
               if (!item.fwd_closed && lock_in == LOCK_FWD) begin
                  lock_in = LOCK_NONE;
                  rsp.switch_event_code = EV_FWD_RELEASED;
               end
               if (!item.rev_closed && lock_in == LOCK_REV) begin
                  lock_in = LOCK_NONE;
                  rsp.switch_event_code = EV_REV_RELEASED;
               end
            end
            REQ_TICK: begin
               if (exec_ff) begin
                  if (index_ff >= count_ff || index_ff >= DEPTH_C) begin
                     // End of store: rewind and stop.
                     index_in = '0;
                     exec_in  = 1'b0;
                  end else begin
                     index_in = index_ff + ONE_C;
                     if (rd_op.code == OP_ROTATE &&
                         !(lock_ff == LOCK_FWD && rd_op.dir == cfg.forward_code) &&
                         !(lock_ff == LOCK_REV && rd_op.dir == cfg.reverse_code)) begin
                        rsp.result_kind     = RES_ROTATE;
                        rsp.move_direction  = rd_op.dir;
                        rsp.move_angle_bits = rd_op.angle;
                        rsp.move_rpm        = rd_op.rpm;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      rsp.executing = exec_in;
   end

   assign rsp_count = count_in;

   // Store ports. The read address is the index that the next request will see.
   assign wr_addr = count_ff[ADDR_W-1:0];
   assign wr_op   = '{code: item.op_code, dir: item.direction_code,
                      angle: item.angle_bits, rpm: item.speed_rpm};
   assign rd_addr = (index_in < DEPTH_C) ? index_in[ADDR_W-1:0] : '0;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         exec_ff  <= 1'b0;
         lock_ff  <= LOCK_NONE;
         count_ff <= '0;
         index_ff <= '0;
      end else begin
         exec_ff  <= exec_in;
         lock_ff  <= lock_in;
         count_ff <= count_in;
         index_ff <= index_in;
      end
   end

   // The replay index never passes the fill count.
   a_index_le_count: assert property (@(posedge clock) disable iff (reset)
      index_ff <= count_ff) else $error("replay index beyond fill count");

   // The fill count never passes the store depth.
   a_count_le_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C) else $error("fill count beyond store depth");

   // Both locks are never held at once.
   a_lock_single: assert property (@(posedge clock) disable iff (reset)
      lock_ff != (LOCK_FWD | LOCK_REV)) else $error("both directions locked");

   // A rotation is only issued from execute mode, which it keeps.
   a_rotate_exec: assert property (@(posedge clock) disable iff (reset)
      (in_valid && rsp.result_kind == RES_ROTATE) |-> (exec_ff && exec_in))
      else $error("rotation issued outside execute mode");

endmodule

[rtl/core/motion_command_buffer_with_limit_lock.sv]
// Top level of the motion command buffer: request register, configuration
// registers, result register. Depends on mcbll_pkg, mcb_ctrl, mcb_op_store.
//
//   channel   handshake              direction  contents
//   request   start / busy           in         req_* fields
//   result    rsp_valid (strobe)     out        rsp_* fields
//   config    csr_valid / csr_ready  in         csr_index, csr_wdata
//
// One request is accepted per cycle while busy is low; its result passes
// the request register and then the result register, which strobes it. The
// store read is registered as well, but it is addressed in the cycle before
// with the replay index that the request will see, so it does not lengthen the path.
// Reset is synchronous and active high; busy is high during reset and for
// the cycle after it. The receiver cannot stall, so results never wait.
module motion_command_buffer_with_limit_lock #(
   parameter int unsigned STORE_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_type,
   input  logic [10:0]                       req_frame_id,
   input  logic [3:0]                        req_frame_len,
   input  logic [7:0]                        req_data_kind,
   input  logic [7:0]                        req_op_code,
   input  logic [7:0]                        req_direction_code,
   input  logic [31:0]                       req_angle_bits,
   input  logic [7:0]                        req_speed_rpm,
   input  logic                              req_forward_switch_closed,
   input  logic                              req_reverse_switch_closed,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_result_kind,
   output logic                              rsp_disable_driver,
   output logic [7:0]                        rsp_move_direction,
   output logic [31:0]                       rsp_move_angle_bits,
   output logic [7:0]                        rsp_move_rpm,
   output logic [2:0]                        rsp_switch_event_code,
   output logic                              rsp_executing,
   output logic [$clog2(STORE_DEPTH+1)-1:0]  rsp_stored_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mcbll_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mcbll_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mcbll_pkg::*;

   localparam int unsigned CNT_W  = $clog2(STORE_DEPTH + 1);
   localparam int unsigned ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   logic             busy_ff;
   logic             in_valid_ff;
   item_type         item_ff, item_in;
   cfg_type          cfg_ff, cfg_in;
   logic             rsp_valid_ff;
   result_type       rsp_ff, rsp_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;

   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic              wr_en;
   op_type            rd_op, wr_op;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;

   // Busy flag covers reset and the cycle after it.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_NODE_ID:    cfg_in.node_id         = csr_wdata;
            REG_STOP_ID:    cfg_in.stop_id         = csr_wdata;
            REG_START_ID:   cfg_in.start_id        = csr_wdata;
            REG_PACKAGE:    cfg_in.package_kind    = csr_wdata[7:0];
            REG_CLEAR:      cfg_in.clear_kind      = csr_wdata[7:0];
            REG_ATTENDANCE: cfg_in.attendance_kind = csr_wdata[7:0];
            REG_FORWARD:    cfg_in.forward_code    = csr_wdata[7:0];
            REG_REVERSE:    cfg_in.reverse_code    = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request register.
   assign item_in = '{req_type: req_type, frame_id: req_frame_id,
                      frame_len: req_frame_len, data_kind: req_data_kind,
                      op_code: req_op_code, direction_code: req_direction_code,
                      angle_bits: req_angle_bits, speed_rpm: req_speed_rpm,
                      fwd_closed: req_forward_switch_closed,
                      rev_closed: req_reverse_switch_closed};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   mcb_op_store #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_op),
      .rd_addr (rd_addr),
      .rd_data (rd_op)
   );

   mcb_ctrl #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (ADDR_W),
      .CNT_W  (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .item      (item_ff),
      .cfg       (cfg_ff),
      .rd_op     (rd_op),
      .rd_addr   (rd_addr),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_op     (wr_op),
      .rsp       (rsp_in),
      .rsp_count (count_in)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         rsp_ff   <= rsp_in;
         count_ff <= count_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_kind       = rsp_ff.result_kind;
   assign rsp_disable_driver    = rsp_ff.disable_driver;
   assign rsp_move_direction    = rsp_ff.move_direction;
   assign rsp_move_angle_bits   = rsp_ff.move_angle_bits;
   assign rsp_move_rpm          = rsp_ff.move_rpm;
   assign rsp_switch_event_code = rsp_ff.switch_event_code;
   assign rsp_executing         = rsp_ff.executing;
   assign rsp_stored_count      = count_ff;

   // Every accepted request yields a result through the request and result registers.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid) else $error("request without result");

   // A result that forces the driver off never reports execute mode.
   a_disable_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_disable_driver) |-> !rsp_executing)
      else $error("driver disabled while executing");

endmodule
